// ===== src/cts_pkg.sv =====
// ----------------------------------------------------------------------------
// Clifford+T state-vector engine package
// Shared types, codes and amplitude arithmetic for the engine.
// ----------------------------------------------------------------------------
package cts_pkg;

  localparam int MaxQubits = 8;
  localparam int AmpCount  = 1 << MaxQubits;
  localparam int AddrW     = MaxQubits;

  localparam logic [2:0] OP_INIT  = 3'd0;
  localparam logic [2:0] OP_H     = 3'd1;
  localparam logic [2:0] OP_T     = 3'd2;
  localparam logic [2:0] OP_S     = 3'd3;
  localparam logic [2:0] OP_Z     = 3'd4;
  localparam logic [2:0] OP_X     = 3'd5;
  localparam logic [2:0] OP_CNOT  = 3'd6;
  localparam logic [2:0] OP_QUERY = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_QUBIT = 2'd1;
  localparam logic [1:0] ST_RANGE    = 2'd2;
  localparam logic [1:0] ST_NOT_REAL = 2'd3;

  // Coefficient c[0] is the constant term, c[3] the w^3 term.
  typedef logic [3:0][63:0] amp_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [2:0] qubit_a;
    logic [2:0] qubit_b;
    logic [7:0] outcome_index;
  } in_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [63:0] prob_integer;
    logic signed [63:0] prob_sqrt2;
    logic [31:0]        prob_denominator_power;
  } out_t;

  typedef struct packed {
    logic        ok;
    logic [63:0] p;
    logic [63:0] q;
  } norm_res_t;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_WLO, S_WHI, S_QREAD, S_QWAIT, S_QMUL, S_DONE
  } state_t;

  // Multiply by w: each term moves up one power, w^4 wraps to -1.
  function automatic amp_t amp_rot(input amp_t a);
    amp_t r;
    r[3] = a[2];
    r[2] = a[1];
    r[1] = a[0];
    r[0] = 64'd0 - a[3];
    return r;
  endfunction

  function automatic amp_t amp_add(input amp_t a, input amp_t b);
    amp_t r;
    for (int i = 0; i < 4; i++) r[i] = a[i] + b[i];
    return r;
  endfunction

  function automatic amp_t amp_sub(input amp_t a, input amp_t b);
    amp_t r;
    for (int i = 0; i < 4; i++) r[i] = a[i] - b[i];
    return r;
  endfunction

endpackage

// ===== src/cts_amp_store.sv =====
// ----------------------------------------------------------------------------
// Amplitude store
// One write port, two registered read ports; per-entry valid bits make an
// unwritten entry read as the initial state.
// ----------------------------------------------------------------------------
module cts_amp_store (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 clr,
  input  logic                 rd_en,
  input  logic [cts_pkg::AddrW-1:0] rd_addr_a,
  input  logic [cts_pkg::AddrW-1:0] rd_addr_b,
  input  logic                 wr_en,
  input  logic [cts_pkg::AddrW-1:0] wr_addr,
  input  cts_pkg::amp_t        wr_data,
  output cts_pkg::amp_t        rd_data_a,
  output cts_pkg::amp_t        rd_data_b
);
  import cts_pkg::*;

  amp_t                mem [AmpCount];
  logic [AmpCount-1:0] valid_r;
  amp_t                mem_a_r, mem_b_r;
  logic                va_r, vb_r, za_r, zb_r;
  amp_t                init_one, init_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (clr) begin
      valid_r <= '0;
    end else if (wr_en) begin
      valid_r[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_a_r <= mem[rd_addr_a];
      mem_b_r <= mem[rd_addr_b];
      va_r    <= valid_r[rd_addr_a];
      vb_r    <= valid_r[rd_addr_b];
      za_r    <= (rd_addr_a == '0);
      zb_r    <= (rd_addr_b == '0);
    end
  end

  always_comb begin
    init_zero    = '0;
    init_one     = '0;
    init_one[0]  = 64'd1;
    rd_data_a = va_r ? mem_a_r : (za_r ? init_one : init_zero);
    rd_data_b = vb_r ? mem_b_r : (zb_r ? init_one : init_zero);
  end

endmodule

// ===== src/cts_norm_unit.sv =====
// ----------------------------------------------------------------------------
// Squared-norm unit
// Forms amp * conj(amp) with one 32x32 multiplier, three partial products
// per 64-bit coefficient product, 48 multiplies in all.
// ----------------------------------------------------------------------------
module cts_norm_unit (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  cts_pkg::amp_t      amp,
  output logic               done,
  output cts_pkg::norm_res_t res
);
  import cts_pkg::*;

  amp_t        amp_r;
  logic [3:0]  pi_r;
  logic [1:0]  ph_r;
  logic        run_r, pend_v_r, pend_sh_r, done_r;
  logic [2:0]  pend_k_r;
  logic [63:0] mul_r;
  logic [63:0] prod_r [7];
  logic [63:0] opa, opb;
  logic [31:0] x, y;
  logic [63:0] r0, r1, r2, r3;

  always_comb begin
    opa = amp_r[pi_r[3:2]];
    // Conjugate: b = {a0, -a3, -a2, -a1}.
    case (pi_r[1:0])
      2'd0:    opb = amp_r[0];
      2'd1:    opb = 64'd0 - amp_r[3];
      2'd2:    opb = 64'd0 - amp_r[2];
      default: opb = 64'd0 - amp_r[1];
    endcase
    x = (ph_r == 2'd2) ? opa[63:32] : opa[31:0];
    y = (ph_r == 2'd1) ? opb[63:32] : opb[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r    <= 1'b0;
      pend_v_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      done_r   <= pend_v_r && !run_r;
      pend_v_r <= run_r;
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && pi_r == 4'd15 && ph_r == 2'd2) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      amp_r <= amp;
      pi_r  <= '0;
      ph_r  <= '0;
      for (int k = 0; k < 7; k++) prod_r[k] <= '0;
    end else begin
      if (run_r) begin
        mul_r     <= x * y;
        pend_sh_r <= (ph_r != 2'd0);
        pend_k_r  <= 3'(pi_r[3:2]) + 3'(pi_r[1:0]);
        if (ph_r == 2'd2) begin
          ph_r <= '0;
          pi_r <= pi_r + 4'd1;
        end else begin
          ph_r <= ph_r + 2'd1;
        end
      end
      if (pend_v_r) begin
        prod_r[pend_k_r] <= prod_r[pend_k_r] +
                            (pend_sh_r ? {mul_r[31:0], 32'd0} : mul_r);
      end
    end
  end

  always_comb begin
    r0 = prod_r[0] - prod_r[4];
    r1 = prod_r[1] - prod_r[5];
    r2 = prod_r[2] - prod_r[6];
    r3 = prod_r[3];
    res.ok = (r2 == 64'd0) && (r3 == 64'd0 - r1);
    res.p  = r0;
    res.q  = r1;
  end

  assign done = done_r;

endmodule

// ===== src/clifford_t_statevector_engine.sv =====
// Init and rejected words go from idle to the done state, then to the output register.
// A gate sweeps all amplitude pairs, each through read both, write low and
// write high, because the amplitude store has a single write port.
// A query waits on the norm unit and its shared 32x32 multiplier.
// Reset is synchronous; the store reads as the initial state right after it.
// ----------------------------------------------------------------------------
// Clifford+T state-vector engine top level
// Sequences gates as read-modify-write sweeps over amplitude pairs and
// answers probability queries through the norm unit.
// ----------------------------------------------------------------------------
module clifford_t_statevector_engine (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  cts_pkg::in_t  in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output cts_pkg::out_t out_data,
  input  logic          cfg_we,
  input  logic [3:0]    cfg_wdata
);
  import cts_pkg::*;

  state_t      state_r, state_nxt;
  logic [3:0]  cfg_r, n_eff, n_r;
  logic [31:0] h_r;
  logic [2:0]  op_r, pos_r;
  logic [7:0]  cm_r, oi_r;
  logic [6:0]  j_r;
  logic [7:0]  lo_r, hi_r, lo_c, last_c;
  amp_t        hi_new_r, new_lo, new_hi, z, o;
  amp_t        cts_rd_a, cts_rd_b;
  out_t        res_r, out_r;
  logic        out_valid_r;
  logic        in_acc, qa_bad, qb_bad, cnot_bad, range_bad;
  logic [1:0]  in_status;
  logic [3:0]  pos_a, pos_b;
  logic        st_clr, st_rd, st_wr;
  logic [7:0]  st_wr_addr, st_rd_a;
  amp_t        st_wr_data;
  logic        norm_start, norm_done;
  norm_res_t   norm_res;

  assign in_acc = in_valid && !in_stall;
  assign n_eff  = (cfg_r == 4'd0) ? 4'd1 :
                  (cfg_r > 4'(MaxQubits)) ? 4'(MaxQubits) : cfg_r;

  assign qa_bad    = {1'b0, in_data.qubit_a} >= n_eff;
  assign qb_bad    = {1'b0, in_data.qubit_b} >= n_eff;
  assign cnot_bad  = qa_bad || qb_bad || (in_data.qubit_a == in_data.qubit_b);
  assign range_bad = ({1'b0, in_data.outcome_index} >> n_eff) != 9'd0;
  assign pos_a     = n_eff - 4'd1 - {1'b0, in_data.qubit_a};
  assign pos_b     = n_eff - 4'd1 - {1'b0, in_data.qubit_b};

  always_comb begin
    in_status = ST_OK;
    if (in_data.opcode == OP_QUERY) begin
      if (range_bad) in_status = ST_RANGE;
    end else if (in_data.opcode == OP_CNOT) begin
      if (cnot_bad) in_status = ST_BAD_QUBIT;
    end else if (in_data.opcode != OP_INIT) begin
      if (qa_bad) in_status = ST_BAD_QUBIT;
    end
  end

  // Low index of pair j: insert a zero at the target bit position.
  always_comb begin
    lo_c   = ((8'(j_r) >> pos_r) << (pos_r + 3'd1)) |
             (8'(j_r) & ((8'd1 << pos_r) - 8'd1));
    last_c = (8'd1 << (n_r - 4'd1)) - 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 4'd1;
    end else if (cfg_we) begin
      cfg_r <= cfg_wdata;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          unique case (in_data.opcode)
            OP_INIT:  state_nxt = S_DONE;
            OP_QUERY: state_nxt = range_bad ? S_DONE : S_QREAD;
            OP_CNOT:  state_nxt = cnot_bad ? S_DONE : S_READ;
            default:  state_nxt = qa_bad ? S_DONE : S_READ;
          endcase
        end
      end
      S_READ:  state_nxt = S_WLO;
      S_WLO:   state_nxt = S_WHI;
      S_WHI:   state_nxt = (8'(j_r) == last_c) ? S_DONE : S_READ;
      S_QREAD: state_nxt = S_QWAIT;
      S_QWAIT: state_nxt = S_QMUL;
      S_QMUL:  state_nxt = norm_done ? S_DONE : S_QMUL;
      S_DONE:  state_nxt = (!out_valid_r || !out_stall) ? S_IDLE : S_DONE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control outputs.
  always_comb begin
    in_stall   = (state_r != S_IDLE);
    st_clr     = in_acc && (in_data.opcode == OP_INIT);
    st_rd      = (state_r == S_READ) || (state_r == S_QREAD);
    st_rd_a    = (state_r == S_QREAD) ? oi_r : lo_c;
    st_wr      = (state_r == S_WLO) || (state_r == S_WHI);
    st_wr_addr = (state_r == S_WLO) ? lo_r : hi_r;
    st_wr_data = (state_r == S_WLO) ? new_lo : hi_new_r;
    norm_start = (state_r == S_QWAIT);
  end

  // Pair update.
  always_comb begin
    z      = cts_rd_a;
    o      = cts_rd_b;
    new_lo = z;
    new_hi = o;
    case (op_r)
      OP_H: begin
        new_lo = amp_add(z, o);
        new_hi = amp_sub(z, o);
      end
      OP_T: new_hi = amp_rot(o);
      OP_S: new_hi = amp_rot(amp_rot(o));
      OP_Z: new_hi = amp_sub('0, o);
      OP_X: begin
        new_lo = o;
        new_hi = z;
      end
      OP_CNOT: begin
        if ((lo_r & cm_r) != 8'd0) begin
          new_lo = o;
          new_hi = z;
        end
      end
      default: ;
    endcase
  end

  cts_amp_store u_store (
    .clk       (clk),
    .rst_n     (rst_n),
    .clr       (st_clr),
    .rd_en     (st_rd),
    .rd_addr_a (st_rd_a),
    .rd_addr_b (lo_c | (8'd1 << pos_r)),
    .wr_en     (st_wr),
    .wr_addr   (st_wr_addr),
    .wr_data   (st_wr_data),
    .rd_data_a (cts_rd_a),
    .rd_data_b (cts_rd_b)
  );

  cts_norm_unit u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (norm_start),
    .amp   (cts_rd_a),
    .done  (norm_done),
    .res   (norm_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      h_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_acc && in_data.opcode == OP_INIT) begin
        h_r <= '0;
      end else if (in_acc && in_data.opcode == OP_H && !qa_bad) begin
        h_r <= h_r + 32'd1;
      end
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= in_data.opcode;
      oi_r  <= in_data.outcome_index;
      n_r   <= n_eff;
      j_r   <= '0;
      res_r <= '{status: in_status, prob_integer: '0, prob_sqrt2: '0,
                 prob_denominator_power: '0};
      if (in_data.opcode == OP_CNOT) begin
        pos_r <= pos_b[2:0];
        cm_r  <= 8'd1 << pos_a[2:0];
      end else begin
        pos_r <= pos_a[2:0];
        cm_r  <= '0;
      end
    end
    if (state_r == S_READ) begin
      lo_r <= lo_c;
      hi_r <= lo_c | (8'd1 << pos_r);
    end
    if (state_r == S_WLO) begin
      hi_new_r <= new_hi;
    end
    if (state_r == S_WHI) begin
      j_r <= j_r + 7'd1;
    end
    if (state_r == S_QMUL && norm_done) begin
      if (norm_res.ok) begin
        res_r.prob_integer           <= norm_res.p;
        res_r.prob_sqrt2             <= norm_res.q;
        res_r.prob_denominator_power <= h_r;
      end else begin
        res_r.status <= ST_NOT_REAL;
      end
    end
    if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
      out_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef SYNTHESIS
  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !st_wr) else $error("store write while idle");
  a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> state_r == S_IDLE) else $error("ready while busy");
  a_norm_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    norm_done |-> state_r == S_QMUL) else $error("norm result outside query");
`endif

endmodule
